// ===== src/sdsb_pkg.sv =====
// Shared types, constants and command-byte helper for the SD-card SPI sequencer.
// No dependencies; every other file in src imports this package.
package sdsb_pkg;

   localparam int BLOCK_BYTES      = 512;
   localparam int IDLE_CLOCK_BYTES = 10;
   localparam int DATA_CLOCKS      = BLOCK_BYTES + 2;
   localparam int BLOCK_SHIFT      = $clog2(BLOCK_BYTES);
   localparam int COUNT_W          = 10;
   localparam int INDEX_W          = 9;
   localparam int BLOCK_W          = 23;
   localparam int MAX_RES          = 2;
   localparam int RSP_DEPTH        = 4;
   localparam int RSP_PTR_W        = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W        = $clog2(RSP_DEPTH + 1);

   localparam logic [7:0] FILL_BYTE   = 8'hFF;
   localparam logic [7:0] DATA_TOKEN  = 8'hFE;
   localparam logic [7:0] CMD0_BYTE   = 8'b01000000;
   localparam logic [7:0] CMD17_BYTE  = 8'b01010001;
   localparam logic [7:0] CMD41_BYTE  = 8'b01101001;
   localparam logic [7:0] CMD55_BYTE  = 8'b01110111;
   localparam logic [7:0] CMD58_BYTE  = 8'b01111010;
   localparam logic [7:0] CRC_CMD0    = 8'b10010101;
   localparam logic [7:0] CRC_DEFAULT = 8'b00000001;

   typedef enum logic [1:0] {
      FUNC_REPLY = 2'd0,
      FUNC_INIT  = 2'd1,
      FUNC_READ  = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      KIND_XFER = 2'd0,
      KIND_DATA = 2'd1,
      KIND_DONE = 2'd2,
      KIND_FAST = 2'd3
   } kind_type;

   typedef enum logic [4:0] {
      PH_IDLE       = 5'd0,
      PH_WAKE       = 5'd1,
      PH_GAP        = 5'd2,
      PH_CMD0       = 5'd3,
      PH_CMD0_POLL  = 5'd4,
      PH_GAP0       = 5'd5,
      PH_CMD55      = 5'd6,
      PH_CMD55_POLL = 5'd7,
      PH_GAP55      = 5'd8,
      PH_CMD41      = 5'd9,
      PH_CMD41_POLL = 5'd10,
      PH_GAP41      = 5'd11,
      PH_CMD58      = 5'd12,
      PH_CMD58_POLL = 5'd13,
      PH_OCR        = 5'd14,
      PH_RD_LEAD    = 5'd15,
      PH_CMD17      = 5'd16,
      PH_CMD17_POLL = 5'd17,
      PH_TOKEN      = 5'd18,
      PH_DATA       = 5'd19
   } phase_type;

   typedef struct packed {
      logic [1:0]         func;
      logic [BLOCK_W-1:0] block_number;
      logic [7:0]         rx_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [7:0]         tx_byte;
      logic               cs_low;
      logic [7:0]         data_byte;
      logic [INDEX_W-1:0] byte_index;
      logic               last;
   } rsp_type;

   // sequencer state; only the reply bits that are ever looked at are kept
   typedef struct packed {
      phase_type          phase;
      logic [COUNT_W-1:0] byte_count;
      logic [BLOCK_W-1:0] block;
      logic               reply_lsb;
      logic [1:0]         ocr_hi;
   } seq_state_type;

   // byte n of the six-byte command frame for the given command phase
   function automatic logic [7:0] cmd_byte(phase_type ph, logic [2:0] n,
                                           logic [BLOCK_W-1:0] blk);
      logic [7:0]  first;
      logic [31:0] addr;
      logic [7:0]  res;
      case (ph)
         PH_CMD0:  first = CMD0_BYTE;
         PH_CMD55: first = CMD55_BYTE;
         PH_CMD41: first = CMD41_BYTE;
         PH_CMD58: first = CMD58_BYTE;
         default:  first = CMD17_BYTE;
      endcase
      addr = {blk, {BLOCK_SHIFT{1'b0}}};
      case (n)
         3'd0:    res = first;
         3'd1:    res = addr[31:24];
         3'd2:    res = addr[23:16];
         3'd3:    res = addr[15:8];
         3'd4:    res = addr[7:0];
         default: res = (ph == PH_CMD0) ? CRC_CMD0 : CRC_DEFAULT;
      endcase
      return res;
   endfunction

   function automatic rsp_type mk_rsp(kind_type kind, logic [7:0] tx, logic cs,
                                      logic [7:0] data, logic [INDEX_W-1:0] idx);
      rsp_type r;
      r.kind       = kind;
      r.tx_byte    = tx;
      r.cs_low     = cs;
      r.data_byte  = data;
      r.byte_index = idx;
      r.last       = 1'b0;
      return r;
   endfunction

endpackage

// ===== src/sdsb_step.sv =====
// Next-state and result logic of the SD-card SPI sequencer for one input item.
// Depends on sdsb_pkg.
module sdsb_step (
   input  sdsb_pkg::seq_state_type                  state,
   input  sdsb_pkg::req_type                        item,
   output sdsb_pkg::seq_state_type                  state_next,
   output sdsb_pkg::rsp_type [sdsb_pkg::MAX_RES-1:0] res,
   output logic [1:0]                               res_cnt
);
   import sdsb_pkg::*;

   logic [COUNT_W-1:0] bc;
   rsp_type            r0;
   rsp_type            r1;
   rsp_type            follow;
   logic [1:0]         cnt;
   seq_state_type      nxt;

   assign bc = state.byte_count + COUNT_W'(1);

   always_comb begin
      nxt    = state;
      cnt    = 2'd0;
      r0     = '0;
      r1     = '0;
      follow = '0;
      case (item.func)
         FUNC_INIT: begin
            nxt.block      = '0;
            nxt.phase      = PH_WAKE;
            nxt.byte_count = '0;
            r0  = mk_rsp(KIND_XFER, FILL_BYTE, 1'b1, '0, '0);
            cnt = 2'd1;
         end
         FUNC_READ: begin
            nxt.block      = item.block_number;
            nxt.phase      = PH_RD_LEAD;
            nxt.byte_count = '0;
            r0  = mk_rsp(KIND_XFER, FILL_BYTE, 1'b0, '0, '0);
            cnt = 2'd1;
         end
         FUNC_REPLY: begin
            cnt = 2'd1;
            case (state.phase)
               PH_WAKE: begin
                  if (bc < COUNT_W'(IDLE_CLOCK_BYTES)) begin
                     nxt.byte_count = bc;
                     r0 = mk_rsp(KIND_XFER, FILL_BYTE, 1'b1, '0, '0);
                  end else begin
                     nxt.phase      = PH_GAP;
                     nxt.byte_count = '0;
                     r0 = mk_rsp(KIND_XFER, FILL_BYTE, 1'b0, '0, '0);
                  end
               end
               PH_GAP: begin
                  nxt.byte_count = (bc < COUNT_W'(2)) ? bc : '0;
                  if (bc < COUNT_W'(2)) begin
                     r0 = mk_rsp(KIND_XFER, FILL_BYTE, 1'b0, '0, '0);
                  end else begin
                     nxt.phase = PH_CMD0;
                     r0 = mk_rsp(KIND_XFER, CMD0_BYTE, 1'b1, '0, '0);
                  end
               end
               PH_CMD0, PH_CMD55, PH_CMD41, PH_CMD58, PH_CMD17: begin
                  if (bc < COUNT_W'(6)) begin
                     nxt.byte_count = bc;
                     r0 = mk_rsp(KIND_XFER, cmd_byte(state.phase, bc[2:0], state.block),
                                 1'b1, '0, '0);
                  end else begin
                     nxt.phase      = phase_type'(state.phase + 5'd1);
                     nxt.byte_count = '0;
                     r0 = mk_rsp(KIND_XFER, FILL_BYTE, 1'b1, '0, '0);
                  end
               end
               PH_CMD0_POLL, PH_CMD55_POLL, PH_CMD41_POLL: begin
                  nxt.reply_lsb = item.rx_byte[0];
                  if (item.rx_byte[7]) begin
                     r0 = mk_rsp(KIND_XFER, FILL_BYTE, 1'b1, '0, '0);
                  end else begin
                     nxt.phase = phase_type'(state.phase + 5'd1);
                     r0 = mk_rsp(KIND_XFER, FILL_BYTE, 1'b0, '0, '0);
                  end
               end
               PH_GAP0: begin
                  nxt.phase      = PH_CMD55;
                  nxt.byte_count = '0;
                  r0 = mk_rsp(KIND_XFER, CMD55_BYTE, 1'b1, '0, '0);
               end
               PH_GAP55: begin
                  nxt.phase      = PH_CMD41;
                  nxt.byte_count = '0;
                  r0 = mk_rsp(KIND_XFER, CMD41_BYTE, 1'b1, '0, '0);
               end
               PH_GAP41: begin
                  // card still idle: run CMD55/ACMD41 again; otherwise go on to CMD58
                  nxt.phase      = state.reply_lsb ? PH_CMD55 : PH_CMD58;
                  nxt.byte_count = '0;
                  r0 = mk_rsp(KIND_XFER, state.reply_lsb ? CMD55_BYTE : CMD58_BYTE,
                              1'b1, '0, '0);
               end
               PH_CMD58_POLL: begin
                  nxt.reply_lsb = item.rx_byte[0];
                  if (!item.rx_byte[7]) begin
                     nxt.phase      = PH_OCR;
                     nxt.byte_count = '0;
                  end
                  r0 = mk_rsp(KIND_XFER, FILL_BYTE, 1'b1, '0, '0);
               end
               PH_OCR: begin
                  if (state.byte_count == COUNT_W'(1)) begin
                     nxt.ocr_hi = item.rx_byte[7:6];
                  end
                  if (bc < COUNT_W'(4)) begin
                     nxt.byte_count = bc;
                     r0 = mk_rsp(KIND_XFER, FILL_BYTE, 1'b1, '0, '0);
                  end else begin
                     nxt.phase      = PH_IDLE;
                     nxt.byte_count = '0;
                     if (state.ocr_hi != 2'b00) begin
                        r0  = mk_rsp(KIND_FAST, '0, 1'b0, '0, '0);
                        r1  = mk_rsp(KIND_DONE, '0, 1'b0, '0, '0);
                        cnt = 2'd2;
                     end else begin
                        r0 = mk_rsp(KIND_DONE, '0, 1'b0, '0, '0);
                     end
                  end
               end
               PH_RD_LEAD: begin
                  nxt.phase      = PH_CMD17;
                  nxt.byte_count = '0;
                  r0 = mk_rsp(KIND_XFER, CMD17_BYTE, 1'b1, '0, '0);
               end
               PH_CMD17_POLL: begin
                  nxt.reply_lsb = item.rx_byte[0];
                  if (item.rx_byte == 8'h00) begin
                     nxt.phase = PH_TOKEN;
                  end
                  r0 = mk_rsp(KIND_XFER, FILL_BYTE, 1'b1, '0, '0);
               end
               PH_TOKEN: begin
                  nxt.reply_lsb = item.rx_byte[0];
                  if (item.rx_byte == DATA_TOKEN) begin
                     nxt.phase      = PH_DATA;
                     nxt.byte_count = '0;
                  end
                  r0 = mk_rsp(KIND_XFER, FILL_BYTE, 1'b1, '0, '0);
               end
               PH_DATA: begin
                  if (bc < COUNT_W'(DATA_CLOCKS)) begin
                     nxt.byte_count = bc;
                     follow = mk_rsp(KIND_XFER, FILL_BYTE, 1'b1, '0, '0);
                  end else begin
                     nxt.phase      = PH_IDLE;
                     nxt.byte_count = '0;
                     follow = mk_rsp(KIND_DONE, '0, 1'b0, '0, '0);
                  end
                  // the two CRC bytes are clocked but not delivered
                  if (state.byte_count < COUNT_W'(BLOCK_BYTES)) begin
                     r0  = mk_rsp(KIND_DATA, '0, 1'b0, item.rx_byte,
                                  state.byte_count[INDEX_W-1:0]);
                     r1  = follow;
                     cnt = 2'd2;
                  end else begin
                     r0 = follow;
                  end
               end
               PH_IDLE: begin
                  cnt = 2'd0;
               end
               default: begin
                  nxt.phase      = PH_IDLE;
                  nxt.byte_count = '0;
                  cnt            = 2'd0;
               end
            endcase
         end
         default: begin
            cnt = 2'd0;
         end
      endcase
      if (cnt == 2'd2) begin
         r1.last = 1'b1;
      end else if (cnt == 2'd1) begin
         r0.last = 1'b1;
      end
   end

   assign state_next = nxt;
   assign res[0]     = r0;
   assign res[1]     = r1;
   assign res_cnt    = cnt;

endmodule

// ===== src/sdsb_rsp_queue.sv =====
// Result queue: takes up to two results per cycle, delivers one per cycle while it is popped.
// Depends on sdsb_pkg.
module sdsb_rsp_queue (
   input  logic                                     clock,
   input  logic                                     reset,
   input  sdsb_pkg::rsp_type [sdsb_pkg::MAX_RES-1:0] din,
   input  logic [1:0]                               push_cnt,
   output logic                                     room,
   output sdsb_pkg::rsp_type                        dout,
   output logic                                     dout_valid,
   input  logic                                     pop
);
   import sdsb_pkg::*;

   rsp_type                entries_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   wr_ptr_ff;
   logic [RSP_PTR_W-1:0]   wr_ptr_in;
   logic [RSP_PTR_W-1:0]   rd_ptr_ff;
   logic [RSP_PTR_W-1:0]   rd_ptr_in;
   logic [RSP_CNT_W-1:0]   count_ff;
   logic [RSP_CNT_W-1:0]   count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(push_cnt);
      rd_ptr_in = rd_ptr_ff + RSP_PTR_W'(pop);
      count_in  = count_ff + RSP_CNT_W'(push_cnt) - RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         entries_ff[wr_ptr_ff] <= din[0];
      end
      if (push_cnt == 2'd2) begin
         entries_ff[wr_ptr_ff + RSP_PTR_W'(1)] <= din[1];
      end
   end

   // room for a worst-case item, judged on registered fill only
   assign room       = count_ff <= RSP_CNT_W'(RSP_DEPTH - MAX_RES);
   assign dout       = entries_ff[rd_ptr_ff];
   assign dout_valid = count_ff != '0;

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= RSP_CNT_W'(RSP_DEPTH))
      else $error("result queue overflow");

   a_push_needs_room: assert property (@(posedge clock) disable iff (reset)
      (push_cnt != 2'd0) |-> room)
      else $error("push into queue without room");

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> (count_ff == '0 && !dout_valid))
      else $error("queue not empty after reset");
`endif

endmodule

// ===== src/sd_spi_init_and_block_read.sv =====
// SD-card SPI-mode sequencer: init and single-block read over a byte-exchange engine.
// The first result of an input transaction is registered in the input stage, then in the result queue.
// Throughput: one input transaction per cycle while each causes one result and the output is not
// stalled; an item causing two results (data byte plus next exchange) can hold input, as
// the 4-entry result queue has a single-result output port.
// Reset (synchronous, active high) returns the sequencer to idle and empties the queue.
module sd_spi_init_and_block_read (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [22:0] block_number, [30:23] rx_byte, [31] zero
   input  logic [1:0]  req_tuser,   // [1:0] func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] tx_byte, [8] cs_low, [16:9] data_byte,
                                    // [25:17] byte_index, [31:26] zero
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast
);
   import sdsb_pkg::*;

   logic                      in_valid_ff;
   logic                      in_valid_in;
   req_type                   in_item_ff;
   seq_state_type             state_ff;
   seq_state_type             state_next;
   rsp_type [MAX_RES-1:0]     res;
   logic [1:0]                res_cnt;
   logic [1:0]                push_cnt;
   logic                      room;
   logic                      consume;
   rsp_type                   head;

   assign consume     = in_valid_ff && room;
   assign req_tready  = !in_valid_ff || consume;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !consume);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff         <= 1'b0;
         state_ff.phase      <= PH_IDLE;
         state_ff.byte_count <= '0;
         state_ff.block      <= '0;
         state_ff.reply_lsb  <= 1'b0;
         state_ff.ocr_hi     <= 2'b00;
      end else begin
         in_valid_ff <= in_valid_in;
         if (consume) begin
            state_ff <= state_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff.func         <= req_tuser;
         in_item_ff.block_number <= req_tdata[BLOCK_W-1:0];
         in_item_ff.rx_byte      <= req_tdata[BLOCK_W+7:BLOCK_W];
      end
   end

   sdsb_step u_step (
      .state      (state_ff),
      .item       (in_item_ff),
      .state_next (state_next),
      .res        (res),
      .res_cnt    (res_cnt)
   );

   assign push_cnt = consume ? res_cnt : 2'd0;

   sdsb_rsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .din        (res),
      .push_cnt   (push_cnt),
      .room       (room),
      .dout       (head),
      .dout_valid (rsp_tvalid),
      .pop        (rsp_tvalid && rsp_tready)
   );

   assign rsp_tdata = {6'd0, head.byte_index, head.data_byte, head.cs_low, head.tx_byte};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

`ifndef SYNTHESIS
   a_idle_reply_silent: assert property (@(posedge clock) disable iff (reset)
      (consume && state_ff.phase == PH_IDLE && in_item_ff.func == FUNC_REPLY)
      |-> (res_cnt == 2'd0))
      else $error("reply in idle produced a result");

   a_init_restarts: assert property (@(posedge clock) disable iff (reset)
      (consume && in_item_ff.func == FUNC_INIT)
      |=> (state_ff.phase == PH_WAKE && state_ff.byte_count == '0 && state_ff.block == '0))
      else $error("init did not restart the wake sequence");

   a_data_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == PH_DATA) |-> (state_ff.byte_count < COUNT_W'(DATA_CLOCKS)))
      else $error("data phase ran past block and CRC");
`endif

endmodule
